[hw/rtl/tapw_pkg.sv]
package tapw_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int PORT_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int TOTAL_W    = PORT_W + CNT_W;
    localparam int CURSOR_W   = 18;
    localparam int STEP_W     = 33;
    localparam int ENTRY_W    = ADDR_W + 2 * PORT_W;
    localparam int LIMIT_SHIFT = 7;
    localparam int LIMIT_MIN  = 1024;
    localparam int LIMIT_MAX  = 8192;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_NEXT  = 2'd2,
        FUNC_MATCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ITER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd1;

    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;

endpackage

[hw/rtl/tapw_if.sv]
interface tapw_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        first_entry;
    logic [31:0] entry_addr;
    logic [15:0] entry_port_low;
    logic [15:0] entry_port_high;
    logic [31:0] start_offset;
    logic [31:0] query_addr;
    logic [15:0] query_port;

    modport source (output valid, func, first_entry, entry_addr, entry_port_low,
                    entry_port_high, start_offset, query_addr, query_port,
                    input ready);
    modport sink (input valid, func, first_entry, entry_addr, entry_port_low,
                  entry_port_high, start_offset, query_addr, query_port,
                  output ready);
endinterface

interface tapw_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic        consecutive;
    logic        matched;
    logic [31:0] limit_in_use;

    modport source (output valid, status, out_addr, out_port, consecutive, matched,
                    limit_in_use, input ready);
    modport sink (input valid, status, out_addr, out_port, consecutive, matched,
                  limit_in_use, output ready);
endinterface

interface tapw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/tapw_ram.sv]
module tapw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[hw/rtl/tapw_divider.sv]
// Restoring remainder unit: one dividend bit per cycle.
module tapw_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  dividend,
    input  logic [tapw_pkg::TOTAL_W-1:0] divisor,
    output logic                         done,
    output logic [tapw_pkg::TOTAL_W-1:0] remainder
);

    localparam int RW = tapw_pkg::TOTAL_W + 1;

    logic          busy_reg;
    logic [5:0]    count_reg;
    logic [31:0]   dvd_reg;
    logic [RW-1:0] rem_reg;
    logic [tapw_pkg::TOTAL_W-1:0] dvs_reg;
    logic [RW-1:0] shifted;
    logic [RW-1:0] diff;

    assign shifted   = {rem_reg[RW-2:0], dvd_reg[31]};
    assign diff      = shifted - {1'b0, dvs_reg};
    assign remainder = rem_reg[tapw_pkg::TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd32;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= (shifted >= {1'b0, dvs_reg}) ? diff : shifted;
        end
    end

endmodule

[hw/rtl/transport_address_pool_walker_top.sv]
// Transport address pool walker.
// Channels: item_in carries one request word (load a range, start at a hash
// offset, next address, match query); result_out returns exactly one result
// word per request; cfg writes iter_mode (index 0) and iter_limit (index 1)
// and is always ready.
// Work per request: load writes one range entry unless the table is full; match
//   reads the stored ranges in turn until one covers the query or the last is
//   checked; next reads the current range, and reads again when the cursor moves
//   to another range; start runs the bit-serial remainder unit and then walks the
//   ranges, or reports empty on an empty table.
// One request is worked at a time; item_in.ready is high only while the
// sequencer is idle. A finished result sits in the output register, and the
// next request is accepted while it waits; that request completes once the
// register has been taken.
// Reset clears the range count, port total, step count, cursor and the output
// valid, and returns iter_mode to automatic and iter_limit to 1024. Range
// storage is not cleared; only loaded entries are ever used.
// When result_out.ready is low the result word holds steady until taken.
module transport_address_pool_walker_top (
    input  logic clk,
    input  logic rst_n,
    tapw_item_if.sink     item_in,
    tapw_result_if.source result_out,
    tapw_cfg_if.sink      cfg
);

    localparam int IW = tapw_pkg::IDX_W;
    localparam int CW = tapw_pkg::CNT_W;
    localparam int TW = tapw_pkg::TOTAL_W;
    localparam int PW = tapw_pkg::PORT_W;
    localparam int UW = tapw_pkg::CURSOR_W;
    localparam int SW = tapw_pkg::STEP_W;
    localparam int EW = tapw_pkg::ENTRY_W;
    localparam logic [CW-1:0] FULL = CW'(tapw_pkg::MAX_RANGES);
    localparam logic [SW-1:0] STEP_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_START, S_DIV, S_WALK_RD, S_WALK_CMP,
        S_NX_RD, S_NX_CHK, S_NX_RD2, S_NX_FIN, S_MT_RD, S_MT_CMP, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    mode_reg;
    logic [31:0]   limit_reg;
    logic [CW-1:0] loaded_reg, loaded_next;
    logic [TW-1:0] total_reg, total_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [IW-1:0] cur_range_reg, cur_range_next;
    logic [UW-1:0] cur_port_reg, cur_port_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [TW-1:0] off_reg, off_next;
    logic          out_valid_reg, out_valid_next;

    // held request word
    logic [1:0]    func_reg;
    logic          first_reg;
    logic [31:0]   eaddr_reg, offset_reg, qaddr_reg;
    logic [PW-1:0] elow_reg, ehigh_reg, qport_reg;

    // result being built, and the output word
    tapw_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [PW-1:0] res_port_reg, res_port_next;
    logic          res_consec_reg, res_consec_next;
    logic          res_match_reg, res_match_next;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_addr_reg, out_limit_reg;
    logic [PW-1:0] out_port_reg;
    logic          out_consec_reg, out_match_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [31:0]   rd_addr;
    logic [PW-1:0] rd_low, rd_high;
    logic          div_start, div_done;
    logic [TW-1:0] div_rem;
    logic          out_load;

    logic [CW-1:0] base;
    logic [PW-1:0] ld_low, ld_high;
    logic [PW:0]   rd_count;
    logic [SW-1:0] steps_inc;
    logic [UW-1:0] port_inc;
    logic [CW-1:0] range_inc;
    logic [31:0]   eff_limit;
    logic [TW-tapw_pkg::LIMIT_SHIFT-1:0] shr;

    tapw_ram #(.WIDTH(EW), .DEPTH(tapw_pkg::MAX_RANGES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    tapw_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (offset_reg),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign rd_addr  = ram_rdata[EW-1 -: 32];
    assign rd_high  = ram_rdata[2*PW-1 -: PW];
    assign rd_low   = ram_rdata[PW-1:0];
    assign rd_count = {1'b0, rd_high} - {1'b0, rd_low} + (PW+1)'(1);

    assign item_in.ready  = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign out_load       = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);

    // effective iteration limit from current registers and port total
    assign shr = total_reg[TW-1:tapw_pkg::LIMIT_SHIFT];
    always_comb
    begin
        if (mode_reg == tapw_pkg::MODE_FIXED)
            eff_limit = limit_reg;
        else if (mode_reg != tapw_pkg::MODE_AUTO)
            eff_limit = '0;
        else if (32'(shr) < 32'(tapw_pkg::LIMIT_MIN))
            eff_limit = 32'(tapw_pkg::LIMIT_MIN);
        else if (32'(shr) > 32'(tapw_pkg::LIMIT_MAX))
            eff_limit = 32'(tapw_pkg::LIMIT_MAX);
        else
            eff_limit = 32'(shr);
    end

    assign base      = first_reg ? '0 : loaded_reg;
    assign ld_low    = (elow_reg > ehigh_reg) ? ehigh_reg : elow_reg;
    assign ld_high   = (elow_reg > ehigh_reg) ? elow_reg : ehigh_reg;
    assign ram_waddr = base[IW-1:0];
    assign ram_wdata = {eaddr_reg, ld_high, ld_low};
    assign steps_inc = (steps_reg == STEP_MAX) ? steps_reg : steps_reg + SW'(1);
    assign port_inc  = cur_port_reg + UW'(1);
    assign range_inc = {1'b0, cur_range_reg} + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        total_next      = total_reg;
        steps_next      = steps_reg;
        cur_range_next  = cur_range_reg;
        cur_port_next   = cur_port_reg;
        idx_next        = idx_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_port_next   = res_port_reg;
        res_consec_next = res_consec_reg;
        res_match_next  = res_match_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;
        out_valid_next  = out_valid_reg;
        if (result_out.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    res_status_next = tapw_pkg::ST_OK;
                    res_addr_next   = '0;
                    res_port_next   = '0;
                    res_consec_next = 1'b0;
                    res_match_next  = 1'b0;
                    idx_next        = '0;
                    case (tapw_pkg::func_t'(item_in.func))
                        tapw_pkg::FUNC_LOAD:  state_next = S_LOAD;
                        tapw_pkg::FUNC_START: state_next = S_START;
                        tapw_pkg::FUNC_NEXT:
                        begin
                            idx_next   = cur_range_reg;
                            state_next = S_NX_RD;
                        end
                        tapw_pkg::FUNC_MATCH:
                            state_next = (loaded_reg == '0) ? S_DONE : S_MT_RD;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD:
            begin
                // clear first when asked, then refuse if the table is full
                loaded_next = base;
                total_next  = first_reg ? '0 : total_reg;
                if (base >= FULL)
                    res_status_next = tapw_pkg::ST_FULL;
                else
                begin
                    ram_we      = 1'b1;
                    loaded_next = base + CW'(1);
                    total_next  = (first_reg ? '0 : total_reg)
                                + TW'({1'b0, ld_high} - {1'b0, ld_low} + (PW+1)'(1));
                end
                state_next = S_DONE;
            end
            S_START:
            begin
                if (loaded_reg == '0)
                begin
                    res_status_next = tapw_pkg::ST_EMPTY;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    off_next   = div_rem;
                    steps_next = '0;
                    idx_next   = '0;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:  state_next = S_WALK_CMP;
            S_WALK_CMP:
            begin
                // place the cursor in the first range that covers the offset
                if (off_reg <= TW'(rd_count) || ({1'b0, idx_reg} + CW'(1)) == loaded_reg)
                begin
                    cur_range_next = idx_reg;
                    cur_port_next  = UW'(rd_low) + UW'(off_reg);
                    state_next     = S_DONE;
                end
                else
                begin
                    off_next   = off_reg - TW'(rd_count);
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_NX_RD:    state_next = S_NX_CHK;
            S_NX_CHK:
            begin
                steps_next = steps_inc;
                if (steps_inc > SW'(total_reg) ||
                    (eff_limit != '0 && steps_inc > SW'(eff_limit)) ||
                    loaded_reg == '0)
                begin
                    res_status_next = tapw_pkg::ST_EXHAUSTED;
                    state_next      = S_DONE;
                end
                else if ({1'b0, cur_range_reg} >= loaded_reg ||
                         port_inc > UW'(rd_high) + UW'(1))
                begin
                    // advance to the next range, wrap past the last
                    cur_range_next = (range_inc >= loaded_reg) ? '0 : range_inc[IW-1:0];
                    idx_next       = (range_inc >= loaded_reg) ? '0 : range_inc[IW-1:0];
                    state_next     = S_NX_RD2;
                end
                else
                begin
                    cur_port_next   = port_inc;
                    res_consec_next = (steps_inc != SW'(1));
                    res_addr_next   = rd_addr;
                    res_port_next   = cur_port_reg[PW-1:0];
                    state_next      = S_DONE;
                end
            end
            S_NX_RD2:   state_next = S_NX_FIN;
            S_NX_FIN:
            begin
                cur_port_next = UW'(rd_low) + UW'(1);
                res_addr_next = rd_addr;
                res_port_next = rd_low;
                state_next    = S_DONE;
            end
            S_MT_RD:    state_next = S_MT_CMP;
            S_MT_CMP:
            begin
                if (rd_addr == qaddr_reg && rd_low <= qport_reg && qport_reg <= rd_high)
                begin
                    res_match_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if (({1'b0, idx_reg} + CW'(1)) == loaded_reg)
                    state_next = S_DONE;
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_MT_RD;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= tapw_pkg::MODE_AUTO;
            limit_reg     <= 32'(tapw_pkg::LIMIT_MIN);
            loaded_reg    <= '0;
            total_reg     <= '0;
            steps_reg     <= '0;
            cur_range_reg <= '0;
            cur_port_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            total_reg     <= total_next;
            steps_reg     <= steps_next;
            cur_range_reg <= cur_range_next;
            cur_port_reg  <= cur_port_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.index == tapw_pkg::CFG_ITER_MODE)
                mode_reg <= cfg.data[1:0];
            if (cfg.valid && cfg.index == tapw_pkg::CFG_ITER_LIMIT)
                limit_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_port_reg   <= res_port_next;
        res_consec_reg <= res_consec_next;
        res_match_reg  <= res_match_next;
        if (item_in.valid && item_in.ready)
        begin
            func_reg   <= item_in.func;
            first_reg  <= item_in.first_entry;
            eaddr_reg  <= item_in.entry_addr;
            elow_reg   <= item_in.entry_port_low;
            ehigh_reg  <= item_in.entry_port_high;
            offset_reg <= item_in.start_offset;
            qaddr_reg  <= item_in.query_addr;
            qport_reg  <= item_in.query_port;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_port_reg   <= res_port_reg;
            out_consec_reg <= res_consec_reg;
            out_match_reg  <= res_match_reg;
            out_limit_reg  <= eff_limit;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = out_status_reg;
    assign result_out.out_addr     = out_addr_reg;
    assign result_out.out_port     = out_port_reg;
    assign result_out.consecutive  = out_consec_reg;
    assign result_out.matched      = out_match_reg;
    assign result_out.limit_in_use = out_limit_reg;

`ifndef SYNTHESIS
    // hold off further requests while one is in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_in.valid && item_in.ready |=> !item_in.ready)
        else $error("request accepted while busy");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= FULL)
        else $error("range count beyond table depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_status_reg == tapw_pkg::ST_FULL |-> loaded_reg == FULL)
        else $error("full status with room in the table");

    a_load_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> func_reg == tapw_pkg::FUNC_LOAD)
        else $error("range write outside a load");
`endif

endmodule

[test/transport_address_pool_walker_top_tb.sv]
module transport_address_pool_walker_top_tb;

    // Modes past fixed all mean "no limit"
    localparam logic [1:0] MODE_INFINITE = 2'd2;
    localparam logic [1:0] MODE_UNLIMITED_ALT = 2'd3;
    localparam logic [tapw_pkg::STEP_W-1:0] STEP_SAT = {tapw_pkg::STEP_W{1'b1}};
    localparam logic [31:0] LIM_RESET = 32'(tapw_pkg::LIMIT_MIN);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET = 1900;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        tapw_pkg::func_t func;
        logic        first_entry;
        logic [31:0] entry_addr;
        logic [15:0] entry_port_low;
        logic [15:0] entry_port_high;
        logic [31:0] start_offset;
        logic [31:0] query_addr;
        logic [15:0] query_port;
    } pool_request_t;

    typedef struct packed {
        tapw_pkg::status_t status;
        logic [31:0] out_addr;
        logic [15:0] out_port;
        logic        consecutive;
        logic        matched;
        logic [31:0] limit_in_use;
    } pool_answer_t;

    typedef struct packed {
        pool_request_t req;
        logic          typed;
        pool_answer_t  ans;
    } directed_row_t;

    logic clk;
    logic rst_n;

    tapw_item_if   item_in ();
    tapw_result_if result_out ();
    tapw_cfg_if    cfg ();

    transport_address_pool_walker_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    // Shadow copy of the pool table, cursor and registers
    logic [31:0]       shadow_addr [tapw_pkg::MAX_RANGES];
    logic [15:0]       shadow_low  [tapw_pkg::MAX_RANGES];
    logic [15:0]       shadow_high [tapw_pkg::MAX_RANGES];
    int unsigned       shadow_loaded;
    int unsigned       shadow_total;
    logic [tapw_pkg::STEP_W-1:0] shadow_steps;
    int unsigned       shadow_cur_range;
    int unsigned       shadow_cur_port;
    logic [1:0]        shadow_mode;
    logic [31:0]       shadow_limit;

    pool_answer_t pending_answers[$];
    int unsigned  failures;
    int unsigned  words_sent;
    int unsigned  burst_left;
    int unsigned  idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Effective iteration limit from the registers and the current port total
    function automatic logic [31:0] limit_now();
        int unsigned scaled;
        if (shadow_mode == tapw_pkg::MODE_FIXED)
            return shadow_limit;
        if (shadow_mode != tapw_pkg::MODE_AUTO)
            return 32'd0;
        scaled = shadow_total >> tapw_pkg::LIMIT_SHIFT;
        if (scaled < tapw_pkg::LIMIT_MIN)
            return 32'(tapw_pkg::LIMIT_MIN);
        if (scaled > tapw_pkg::LIMIT_MAX)
            return 32'(tapw_pkg::LIMIT_MAX);
        return scaled;
    endfunction

    // Advance the shadow pool by one request and return the answer it owes
    function automatic pool_answer_t walk_predict(pool_request_t r);
        pool_answer_t a;
        logic [15:0]  lo;
        logic [15:0]  hi;
        int unsigned  off;
        int unsigned  span;
        logic [31:0]  lim;
        a = '0;
        a.status = tapw_pkg::ST_OK;
        case (r.func)
            tapw_pkg::FUNC_LOAD:
            begin
                lo = r.entry_port_low;
                hi = r.entry_port_high;
                if (r.first_entry)
                begin
                    shadow_loaded = 0;
                    shadow_total = 0;
                end
                if (shadow_loaded >= tapw_pkg::MAX_RANGES)
                    a.status = tapw_pkg::ST_FULL;
                else
                begin
                    if (lo > hi)
                    begin
                        lo = r.entry_port_high;
                        hi = r.entry_port_low;
                    end
                    shadow_addr[shadow_loaded] = r.entry_addr;
                    shadow_low[shadow_loaded] = lo;
                    shadow_high[shadow_loaded] = hi;
                    shadow_total += 32'(hi) - 32'(lo) + 1;
                    shadow_loaded++;
                end
            end
            tapw_pkg::FUNC_START:
            begin
                if (shadow_loaded == 0 || shadow_total == 0)
                    a.status = tapw_pkg::ST_EMPTY;
                else
                begin
                    off = r.start_offset % shadow_total;
                    shadow_steps = '0;
                    for (int i = 0; i < shadow_loaded; i++)
                    begin
                        span = 32'(shadow_high[i]) - 32'(shadow_low[i]) + 1;
                        if (off <= span)
                        begin
                            shadow_cur_range = i;
                            shadow_cur_port = 32'(shadow_low[i]) + off;
                            break;
                        end
                        off -= span;
                    end
                end
            end
            tapw_pkg::FUNC_NEXT:
            begin
                lim = limit_now();
                if (shadow_steps != STEP_SAT)
                    shadow_steps++;
                if (shadow_steps > 33'(shadow_total) ||
                    (lim != 0 && shadow_steps > 33'(lim)) || shadow_loaded == 0)
                    a.status = tapw_pkg::ST_EXHAUSTED;
                else
                begin
                    shadow_cur_port++;
                    if (shadow_cur_range >= shadow_loaded ||
                        shadow_cur_port > 32'(shadow_high[shadow_cur_range]) + 1)
                    begin
                        shadow_cur_range++;
                        if (shadow_cur_range >= shadow_loaded)
                            shadow_cur_range = 0;
                        shadow_cur_port = 32'(shadow_low[shadow_cur_range]) + 1;
                    end
                    else
                        a.consecutive = (shadow_steps != 1);
                    a.out_addr = shadow_addr[shadow_cur_range];
                    a.out_port = 16'(shadow_cur_port - 1);
                end
            end
            default:
            begin
                for (int i = 0; i < shadow_loaded; i++)
                    if (shadow_addr[i] == r.query_addr && shadow_low[i] <= r.query_port &&
                        r.query_port <= shadow_high[i])
                    begin
                        a.matched = 1'b1;
                        break;
                    end
            end
        endcase
        a.limit_in_use = limit_now();
        return a;
    endfunction

    function automatic pool_request_t make_req(tapw_pkg::func_t f, logic first,
                                               logic [31:0] addr,
                                               logic [15:0] lo, logic [15:0] hi,
                                               logic [31:0] off, logic [31:0] qa,
                                               logic [15:0] qp);
        pool_request_t r;
        r.func = f;
        r.first_entry = first;
        r.entry_addr = addr;
        r.entry_port_low = lo;
        r.entry_port_high = hi;
        r.start_offset = off;
        r.query_addr = qa;
        r.query_port = qp;
        return r;
    endfunction

    function automatic pool_answer_t make_ans(tapw_pkg::status_t st, logic hit,
                                              logic [31:0] lim);
        pool_answer_t a;
        a = '0;
        a.status = st;
        a.matched = hit;
        a.limit_in_use = lim;
        return a;
    endfunction

    // Drive one word; gaps fall between bursts. Valid stays high after acceptance
    // so that a back-to-back word needs only one assignment in the step.
    task automatic send_word(pool_request_t r, logic typed = 1'b0,
                             pool_answer_t typed_ans = '0);
        pool_answer_t predicted;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_in.valid           <= 1'b1;
        item_in.func            <= r.func;
        item_in.first_entry     <= r.first_entry;
        item_in.entry_addr      <= r.entry_addr;
        item_in.entry_port_low  <= r.entry_port_low;
        item_in.entry_port_high <= r.entry_port_high;
        item_in.start_offset    <= r.start_offset;
        item_in.query_addr      <= r.query_addr;
        item_in.query_port      <= r.query_port;
        do
            @(posedge clk);
        while (!item_in.ready);
        predicted = walk_predict(r);
        pending_answers.push_back(typed ? typed_ans : predicted);
        words_sent++;
    endtask

    // Hold the sender until every owed answer has come back
    task automatic drain_answers();
        item_in.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Program both registers while the block is idle
    task automatic program_limit(logic [1:0] mode, logic [31:0] lim);
        drain_answers();
        cfg.valid <= 1'b1;
        cfg.index <= tapw_pkg::CFG_ITER_MODE;
        cfg.data  <= 32'(mode);
        do
            @(posedge clk);
        while (!cfg.ready);
        shadow_mode = mode;
        cfg.index <= tapw_pkg::CFG_ITER_LIMIT;
        cfg.data  <= lim;
        do
            @(posedge clk);
        while (!cfg.ready);
        shadow_limit = lim;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random sequence: mostly pool build, start, run of nexts and lookups
    task automatic random_sequence();
        int unsigned n;
        int unsigned steps;
        logic        wide;
        logic [31:0] addr;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [31:0] last_addr;
        logic [15:0] last_port;
        if ($urandom_range(0, 9) == 0)
        begin
            send_word(make_req(tapw_pkg::func_t'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                               16'($urandom), $urandom, $urandom, 16'($urandom)));
            return;
        end
        last_addr = $urandom;
        last_port = 16'($urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            // rebuild the pool, now and then overfilling it
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
            wide = ($urandom_range(0, 7) == 0);
            addr = $urandom;
            for (int k = 0; k < n; k++)
            begin
                if (wide)
                begin
                    lo = 16'h0000;
                    hi = 16'hFFFF;
                end
                else
                begin
                    lo = 16'($urandom);
                    hi = (lo > 16'hFFF0) ? 16'hFFFF : lo + 16'($urandom_range(0, 6));
                    if ($urandom_range(0, 7) == 0)
                        {lo, hi} = {hi, lo};
                end
                send_word(make_req(tapw_pkg::FUNC_LOAD, k == 0, addr, lo, hi, $urandom,
                                   $urandom, 16'($urandom)));
                last_addr = addr;
                last_port = lo;
                addr = addr + $urandom_range(0, 3);
            end
        end
        if ($urandom_range(0, 7) != 0)
            send_word(make_req(tapw_pkg::FUNC_START, 1'($urandom_range(0, 1)), $urandom,
                               16'($urandom), 16'($urandom), $urandom, $urandom,
                               16'($urandom)));
        steps = (shadow_total < 60 && $urandom_range(0, 2) == 0) ? shadow_total + 3
                                                                 : $urandom_range(1, 30);
        for (int k = 0; k < steps; k++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_word(make_req(tapw_pkg::FUNC_MATCH, 1'($urandom_range(0, 1)),
                                       $urandom, 16'($urandom), 16'($urandom), $urandom,
                                       last_addr, last_port + 16'($urandom_range(0, 2))));
                else
                    send_word(make_req(tapw_pkg::FUNC_MATCH, 1'($urandom_range(0, 1)),
                                       $urandom, 16'($urandom), 16'($urandom), $urandom,
                                       $urandom, 16'($urandom)));
            end
            send_word(make_req(tapw_pkg::FUNC_NEXT, 1'($urandom_range(0, 1)), $urandom,
                               16'($urandom), 16'($urandom), $urandom, $urandom,
                               16'($urandom)));
        end
    endtask

    // Receiver: rotate through three stall patterns and check each answer word
    int unsigned rx_cycle;
    always @(posedge clk or negedge rst_n)
    begin
        pool_answer_t want;
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle >> 6) % 3)
                0:       result_out.ready <= 1'b1;
                1:       result_out.ready <= ($urandom_range(0, 1) == 0);
                default: result_out.ready <= ($urandom_range(0, 3) == 0);
            endcase
            if (result_out.valid && result_out.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected answer word, status %0d", $time,
                             result_out.status);
                    failures++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (result_out.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, result_out.status);
                        failures++;
                    end
                    if (result_out.out_addr !== want.out_addr)
                    begin
                        $display("%0t: out_addr expected %h actual %h", $time,
                                 want.out_addr, result_out.out_addr);
                        failures++;
                    end
                    if (result_out.out_port !== want.out_port)
                    begin
                        $display("%0t: out_port expected %h actual %h", $time,
                                 want.out_port, result_out.out_port);
                        failures++;
                    end
                    if (result_out.consecutive !== want.consecutive)
                    begin
                        $display("%0t: consecutive expected %b actual %b", $time,
                                 want.consecutive, result_out.consecutive);
                        failures++;
                    end
                    if (result_out.matched !== want.matched)
                    begin
                        $display("%0t: matched expected %b actual %b", $time,
                                 want.matched, result_out.matched);
                        failures++;
                    end
                    if (result_out.limit_in_use !== want.limit_in_use)
                    begin
                        $display("%0t: limit_in_use expected %0d actual %0d", $time,
                                 want.limit_in_use, result_out.limit_in_use);
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (item_in.valid && item_in.ready) ||
            (result_out.valid && result_out.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d answers outstanding", $time,
                     pending_answers.size());
            $display("** transport_address_pool_walker_top: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    directed_row_t directed_rows[$];

    initial
    begin
        logic [1:0]  phase_mode [8];
        logic [31:0] phase_limit [8];
        int unsigned phase_end;

        failures = 0;
        words_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        shadow_loaded = 0;
        shadow_total = 0;
        shadow_steps = '0;
        shadow_cur_range = 0;
        shadow_cur_port = 0;
        shadow_mode = tapw_pkg::MODE_AUTO;
        shadow_limit = LIM_RESET;

        rst_n                   <= 1'b0;
        item_in.valid           <= 1'b0;
        item_in.func            <= tapw_pkg::FUNC_LOAD;
        item_in.first_entry     <= 1'b0;
        item_in.entry_addr      <= '0;
        item_in.entry_port_low  <= '0;
        item_in.entry_port_high <= '0;
        item_in.start_offset    <= '0;
        item_in.query_addr      <= '0;
        item_in.query_port      <= '0;
        cfg.valid               <= 1'b0;
        cfg.index               <= tapw_pkg::CFG_ITER_MODE;
        cfg.data                <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extreme ranges, swapped ports, lookups, walks
        directed_rows.push_back({make_req(tapw_pkg::FUNC_START, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h1234, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_EMPTY, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_NEXT, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_EXHAUSTED, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_MATCH, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_LOAD, 1'b1, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_LOAD, 1'b0, 32'hFFFF_FFFF,
                                          16'hFFFF, 16'h0, 32'h0, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_LOAD, 1'b0, 32'h0A00_0001,
                                          16'd1000, 16'd1003, 32'h0, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_MATCH, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'h0, 16'h0), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b1, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_MATCH, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'hFFFF_FFFF, 16'hFFFF), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b1, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_MATCH, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'h0A00_0001, 16'd1004), 1'b1,
                                 make_ans(tapw_pkg::ST_OK, 1'b0, LIM_RESET)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_NEXT, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'h0, 32'h0, 16'h0), 1'b0,
                                 pool_answer_t'('0)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_START, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'hFFFF_FFFF, 32'h0, 16'h0), 1'b0,
                                 pool_answer_t'('0)});
        for (int k = 0; k < 5; k++)
            directed_rows.push_back({make_req(tapw_pkg::FUNC_NEXT, 1'b0, 32'h0, 16'h0,
                                              16'h0, 32'h0, 32'h0, 16'h0), 1'b0,
                                     pool_answer_t'('0)});
        directed_rows.push_back({make_req(tapw_pkg::FUNC_START, 1'b0, 32'h0, 16'h0, 16'h0,
                                          32'd65540, 32'h0, 16'h0), 1'b0,
                                 pool_answer_t'('0)});
        for (int k = 0; k < 6; k++)
            directed_rows.push_back({make_req(tapw_pkg::FUNC_NEXT, 1'b0, 32'h0, 16'h0,
                                              16'h0, 32'h0, 32'h0, 16'h0), 1'b0,
                                     pool_answer_t'('0)});
        foreach (directed_rows[k])
            send_word(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].ans);

        // Random phases across every limit setting, extremes among them
        phase_mode  = '{tapw_pkg::MODE_AUTO, tapw_pkg::MODE_FIXED, tapw_pkg::MODE_FIXED,
                        tapw_pkg::MODE_FIXED, tapw_pkg::MODE_FIXED, MODE_INFINITE,
                        MODE_UNLIMITED_ALT, tapw_pkg::MODE_AUTO};
        phase_limit = '{32'd1024, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'hA5A5_5A5A,
                        32'd7, 32'd1024};
        for (int p = 0; p < 8; p++)
        begin
            program_limit(phase_mode[p], phase_limit[p]);
            phase_end = words_sent + ITEM_TARGET / 8;
            while (words_sent < phase_end)
                random_sequence();
        end

        drain_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("** transport_address_pool_walker_top: PASSED **");
        else
            $display("** transport_address_pool_walker_top: FAILED **");
        $finish;
    end

endmodule
